// ----- rtl/core/bqf_pkg.sv -----
// Shared constants for the biquad audio filter: register map and gain format.
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

	// gain format, unsigned Q1.15
	localparam int GAIN_WIDTH = 16;
	localparam int GAIN_FRAC  = 15;

	// APB geometry: six 32-bit registers at 4*i
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	// register indexes (paddr[4:2])
	localparam logic [REG_IDX_W-1:0] REG_B0   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B1   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_B2   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A1   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A2   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/core/bqf_in_if.sv -----
// Input sample stream interface: valid/ready plus sample and first-sample flag.
`timescale 1ns / 1ps
`default_nettype none

interface bqf_in_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic                           first_sample;

	modport source (output valid, output sample_in, output first_sample, input ready);
	modport sink (input valid, input sample_in, input first_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bqf_out_if.sv -----
// Output sample stream interface: valid/ready plus filtered sample.
`timescale 1ns / 1ps
`default_nettype none

interface bqf_out_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bqf_regs.sv -----
// APB register file holding the five filter coefficients and the output gain.
`timescale 1ns / 1ps
`default_nettype none

module bqf_regs import bqf_pkg::*; #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [APB_ADDR_W-1:0]        paddr,
	input  wire logic [APB_DATA_W-1:0]        pwdata,
	output logic      [APB_DATA_W-1:0]        prdata,
	output logic                              pready,
	output logic signed [COEF_FRAC_BITS+1:0]  coef_b0,
	output logic signed [COEF_FRAC_BITS+1:0]  coef_b1,
	output logic signed [COEF_FRAC_BITS+1:0]  coef_b2,
	output logic signed [COEF_FRAC_BITS+1:0]  coef_a1,
	output logic signed [COEF_FRAC_BITS+1:0]  coef_a2,
	output logic        [GAIN_WIDTH-1:0]      output_gain
);

	localparam int CW = COEF_FRAC_BITS + 2;
	localparam logic signed [CW-1:0] B0_RESET = CW'(1) << COEF_FRAC_BITS;
	localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(1) << GAIN_FRAC;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0     <= B0_RESET;
			coef_b1     <= '0;
			coef_b2     <= '0;
			coef_a1     <= '0;
			coef_a2     <= '0;
			output_gain <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_B0:   coef_b0     <= signed'(pwdata[CW-1:0]);
				REG_B1:   coef_b1     <= signed'(pwdata[CW-1:0]);
				REG_B2:   coef_b2     <= signed'(pwdata[CW-1:0]);
				REG_A1:   coef_a1     <= signed'(pwdata[CW-1:0]);
				REG_A2:   coef_a2     <= signed'(pwdata[CW-1:0]);
				REG_GAIN: output_gain <= pwdata[GAIN_WIDTH-1:0];
				default:  ; // unmapped slots ignore writes
			endcase
		end
	end

	// coefficients read back sign-extended
	always_comb begin
		unique case (idx)
			REG_B0:   prdata = APB_DATA_W'(coef_b0);
			REG_B1:   prdata = APB_DATA_W'(coef_b1);
			REG_B2:   prdata = APB_DATA_W'(coef_b2);
			REG_A1:   prdata = APB_DATA_W'(coef_a1);
			REG_A2:   prdata = APB_DATA_W'(coef_a2);
			REG_GAIN: prdata = APB_DATA_W'(output_gain);
			default:  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/bqf_section.sv -----
// Biquad section: input register, direct form I arithmetic, delay line, y register.
`timescale 1ns / 1ps
`default_nettype none

module bqf_section #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bqf_in_if.sink                              raw,
	input  wire logic signed [COEF_FRAC_BITS+1:0] coef_b0,
	input  wire logic signed [COEF_FRAC_BITS+1:0] coef_b1,
	input  wire logic signed [COEF_FRAC_BITS+1:0] coef_b2,
	input  wire logic signed [COEF_FRAC_BITS+1:0] coef_a1,
	input  wire logic signed [COEF_FRAC_BITS+1:0] coef_a2,
	output logic                                y_valid,
	input  wire logic                           y_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      y
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int PW = CW + SW;
	localparam int AW = PW + 3;   // five terms
	localparam logic signed [AW-1:0] HALF  = AW'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [AW-1:0] Y_MAX = (AW'(1) << (SW - 1)) - AW'(1);
	localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);

	// stage 1: accepted word
	logic                 valid_s1;
	logic signed [SW-1:0] x_s1;
	logic                 first_s1;
	// stage 2: filter output
	logic                 valid_s2;
	logic signed [SW-1:0] y_s2;
	// delay line
	logic signed [SW-1:0] x1_q, x2_q, y1_q, y2_q;

	logic                 ready_s1, fire_s1, ready_s2;
	logic signed [SW-1:0] x1_e, x2_e, y1_e, y2_e;
	logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [AW-1:0] acc, acc_rnd, acc_sh;
	logic signed [SW-1:0] y_next;

	assign ready_s2  = !valid_s2 || y_ready;
	assign fire_s1   = valid_s1 && ready_s2;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign raw.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && raw.valid) begin
			x_s1     <= raw.sample_in;
			first_s1 <= raw.first_sample;
		end
	end

	// first sample of a sound sees cleared delays
	always_comb begin
		x1_e = first_s1 ? '0 : x1_q;
		x2_e = first_s1 ? '0 : x2_q;
		y1_e = first_s1 ? '0 : y1_q;
		y2_e = first_s1 ? '0 : y2_q;
	end

	always_comb begin
		p_b0    = PW'(coef_b0) * PW'(x_s1);
		p_b1    = PW'(coef_b1) * PW'(x1_e);
		p_b2    = PW'(coef_b2) * PW'(x2_e);
		p_a1    = PW'(coef_a1) * PW'(y1_e);
		p_a2    = PW'(coef_a2) * PW'(y2_e);
		acc     = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a1) - AW'(p_a2);
		acc_rnd = acc + HALF;
		acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
		if (acc_sh > Y_MAX) begin
			y_next = Y_MAX[SW-1:0];
		end else if (acc_sh < Y_MIN) begin
			y_next = Y_MIN[SW-1:0];
		end else begin
			y_next = acc_sh[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (fire_s1) begin
			x2_q <= x1_e;
			x1_q <= x_s1;
			y2_q <= y1_e;
			y1_q <= y_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			y_s2 <= y_next;
		end
	end

	assign y_valid = valid_s2;
	assign y       = y_s2;

	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && first_s1 |=> x2_q == '0 && y2_q == '0)
		else $error("first sample did not clear the second delays");

	a_delay_load: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> x1_q == $past(x_s1) && y1_q == y_s2)
		else $error("delay line out of step with the filter output");

	a_y_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !y_ready |=> valid_s2 && $stable(y_s2) && $stable(y1_q))
		else $error("stalled filter output or delay changed");

endmodule

`default_nettype wire

// ----- rtl/core/bqf_gain.sv -----
// Output gain stage: Q1.15 gain multiply, rounding, saturation, output register.
`timescale 1ns / 1ps
`default_nettype none

module bqf_gain import bqf_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [GAIN_WIDTH-1:0]         output_gain,
	input  wire logic                          y_valid,
	output logic                               y_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] y,
	bqf_out_if.source                          filtered
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int GW = SW + GAIN_WIDTH + 1;
	localparam logic signed [GW-1:0] HALF  = GW'(1) << (GAIN_FRAC - 1);
	localparam logic signed [GW-1:0] S_MAX = (GW'(1) << (SW - 1)) - GW'(1);
	localparam logic signed [GW-1:0] S_MIN = -S_MAX - GW'(1);

	logic                        valid_s3;
	logic signed [SW-1:0]        sample_out_s3;
	logic signed [GAIN_WIDTH:0]  gain_sx;
	logic signed [GW-1:0]        prod, prod_rnd, prod_sh;
	logic signed [SW-1:0]        g_next;

	assign y_ready = !valid_s3 || filtered.ready;

	always_comb begin
		gain_sx  = signed'({1'b0, output_gain});
		prod     = GW'(y) * GW'(gain_sx);
		prod_rnd = prod + HALF;
		prod_sh  = prod_rnd >>> GAIN_FRAC;
		if (prod_sh > S_MAX) begin
			g_next = S_MAX[SW-1:0];
		end else if (prod_sh < S_MIN) begin
			g_next = S_MIN[SW-1:0];
		end else begin
			g_next = prod_sh[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (y_ready) begin
			valid_s3 <= y_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (y_ready && y_valid) begin
			sample_out_s3 <= g_next;
		end
	end

	assign filtered.valid      = valid_s3;
	assign filtered.sample_out = sample_out_s3;

endmodule

`default_nettype wire

// ----- rtl/core/biquad_audio_filter_core.sv -----
// Biquad audio filter top level: APB registers, biquad section, output gain.
// A word accepted into the stage 1 register passes through the y register to the output
// register and leaves from there on the output handshake.
// Throughput: one word per cycle unless the output stalls, as the delays load on the same edge as y.
// Reset (arst_n low, asynchronous): pipeline empty, delays zero, b0 = 1.0, gain = 1.0.
// Output register holds a waiting result; input is still taken while stage 1 or stage 2 has room.
`timescale 1ns / 1ps
`default_nettype none

module biquad_audio_filter_core import bqf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	// sample streams, SAMPLE_WIDTH wide
	bqf_in_if.sink                     raw,
	bqf_out_if.source                  filtered
);

	localparam int CW = COEF_FRAC_BITS + 2;

	// coefficient set, Q2.COEF_FRAC_BITS
	logic signed [CW-1:0]         coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	logic        [GAIN_WIDTH-1:0] output_gain;

	// filter output y between section and gain stage
	logic                          y_valid, y_ready;
	logic signed [SAMPLE_WIDTH-1:0] y;

	// the user must change registers only while the datapath is idle; the block does not enforce this, no shadowing
	bqf_regs #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.coef_b0     (coef_b0),
		.coef_b1     (coef_b1),
		.coef_b2     (coef_b2),
		.coef_a1     (coef_a1),
		.coef_a2     (coef_a2),
		.output_gain (output_gain)
	);

	// stage 1 register -> five products and accumulate -> y register (stage 2);
	// the delays update on the same edge that loads y, which closes the feedback loop
	bqf_section #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_section (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw),
		.coef_b0 (coef_b0),
		.coef_b1 (coef_b1),
		.coef_b2 (coef_b2),
		.coef_a1 (coef_a1),
		.coef_a2 (coef_a2),
		.y_valid (y_valid),
		.y_ready (y_ready),
		.y       (y)
	);

	// gain multiply sits after the y register and fills the output register (stage 3)
	bqf_gain #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_gain (
		.clk         (clk),
		.arst_n      (arst_n),
		.output_gain (output_gain),
		.y_valid     (y_valid),
		.y_ready     (y_ready),
		.y           (y),
		.filtered    (filtered)
	);

endmodule

`default_nettype wire
